@@ rtl/core/lspwm_pkg.sv @@
// Shared types and constants for the LED shift-register PWM frame driver.
`timescale 1ns / 1ps
`default_nettype none
package lspwm_pkg;

	localparam int COLOURS_PER_BOARD = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int QPW = $clog2(QUEUE_DEPTH);

	localparam logic [6:0] BOARD_COUNT_RST = 7'd50;
	localparam logic [7:0] SYNC_BYTE_RST = 8'd66;

	localparam logic [7:0] THRESH [32] = '{
		8'd212, 8'd84, 8'd228, 8'd44, 8'd204, 8'd148, 8'd244, 8'd156,
		8'd12, 8'd108, 8'd124, 8'd220, 8'd68, 8'd76, 8'd164, 8'd236,
		8'd100, 8'd180, 8'd196, 8'd188, 8'd140, 8'd116, 8'd28, 8'd52,
		8'd36, 8'd60, 8'd132, 8'd252, 8'd20, 8'd4, 8'd172, 8'd92
	};

	// colour byte offset within a board for each bit slot
	localparam logic [2:0] SLOT_OFFSET [8] = '{
		3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0
	};

	typedef enum logic [1:0] {
		CFG_BOARD_COUNT = 2'd0,
		CFG_SYNC_BYTE   = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic serial_bit;
		logic frame_end;
	} result_t;

	typedef struct packed {
		logic [6:0] board_count;
		logic [7:0] sync_byte;
	} cfg_t;

	typedef struct packed {
		logic [7:0] colour;
		logic [7:0] thr;
		logic       hit;
		logic       frame_end;
	} qent_t;

endpackage
`default_nettype wire

@@ rtl/core/lspwm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lspwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 384,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ rtl/core/lspwm_front.sv @@
// Front end: request intake, colour store writes, scan sequencing and store read.
`timescale 1ns / 1ps
`default_nettype none
module lspwm_front
	import lspwm_pkg::*;
#(
	parameter int BOARDS = 64,
	parameter int PHASES = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cfg_t           cfg,
	input  wire logic           item_valid,
	output logic                item_stall,
	input  wire item_t          item_data,
	input  wire logic [QCW-1:0] queue_level,
	output logic                push,
	output qent_t               push_data
);

	localparam int STORE = BOARDS * COLOURS_PER_BOARD;
	localparam int AW = $clog2(STORE);
	localparam int WAW = $clog2(STORE + 1);
	localparam int BW = (BOARDS > 1) ? $clog2(BOARDS) : 1;
	localparam int CW = $clog2(BOARDS + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam int PW = $clog2(PHASES);

	logic [WAW-1:0] wr_addr_q;
	logic [WAW-1:0] fill_q;
	logic [BW-1:0]  board_pos_q;
	logic [2:0]     bit_pos_q;
	logic [PW-1:0]  phase_q;

	logic       valid_s1;
	logic [7:0] thr_s1;
	logic       hit_s1;
	logic       last_s1;

	logic           accept;
	logic           tick;
	logic           byte_wr;
	logic [QCW-1:0] occupancy;
	logic [CMPW-1:0] bc_w;
	logic [CW-1:0]  eff;
	logic           restart;
	logic [BW-1:0]  bp;
	logic [2:0]     bt;
	logic           first;
	logic [PW-1:0]  phase_inc;
	logic [PW-1:0]  phase_use;
	logic [CW-1:0]  board;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     thr;
	logic           last;
	logic [BW-1:0]  board_next;
	logic [2:0]     bit_next;
	logic [7:0]     rd_colour;

	assign occupancy = queue_level + QCW'(valid_s1);
	assign item_stall = (occupancy >= QCW'(QUEUE_DEPTH));
	assign accept = item_valid && !item_stall;
	assign tick = accept && item_data.mode;
	assign byte_wr = accept && !item_data.mode && (item_data.data_byte != cfg.sync_byte)
		&& (wr_addr_q < WAW'(STORE));

	assign bc_w = CMPW'(cfg.board_count);

	always_comb begin
		if (bc_w == '0) begin
			eff = CW'(1);
		end else if (bc_w > CMPW'(BOARDS)) begin
			eff = CW'(BOARDS);
		end else begin
			eff = CW'(bc_w);
		end
	end

	always_comb begin
		restart = (CW'(board_pos_q) >= eff);
		bp = restart ? '0 : board_pos_q;
		bt = restart ? '0 : bit_pos_q;
		first = (bp == '0) && (bt == '0);
		phase_inc = (phase_q == PW'(PHASES - 1)) ? '0 : phase_q + PW'(1);
		phase_use = first ? phase_inc : phase_q;
		board = eff - CW'(1) - CW'(bp);
		rd_addr = AW'(board) * AW'(COLOURS_PER_BOARD) + AW'(SLOT_OFFSET[bt]);
		thr = THRESH[5'(phase_use)];
		last = (bt == 3'd7) && ((CW'(bp) + CW'(1)) >= eff);
		if (bt == 3'd7) begin
			bit_next = '0;
			board_next = last ? '0 : bp + BW'(1);
		end else begin
			bit_next = bt + 3'd1;
			board_next = bp;
		end
	end

	lspwm_ram #(
		.WIDTH (8),
		.DEPTH (STORE)
	) u_store (
		.clk     (clk),
		.wr_en   (byte_wr),
		.wr_addr (AW'(wr_addr_q)),
		.wr_data (item_data.data_byte),
		.rd_en   (tick),
		.rd_addr (rd_addr),
		.rd_data (rd_colour)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_addr_q <= '0;
			fill_q <= '0;
			board_pos_q <= '0;
			bit_pos_q <= '0;
			phase_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tick;
			if (accept && !item_data.mode) begin
				if (item_data.data_byte == cfg.sync_byte) begin
					wr_addr_q <= '0;
				end else if (byte_wr) begin
					wr_addr_q <= wr_addr_q + WAW'(1);
					if (wr_addr_q == fill_q) begin
						fill_q <= fill_q + WAW'(1);
					end
				end
			end
			if (tick) begin
				board_pos_q <= board_next;
				bit_pos_q <= bit_next;
				phase_q <= phase_use;
			end
		end
	end

	// entries at or above the fill mark were never written and read as zero
	always_ff @(posedge clk) begin
		if (tick) begin
			thr_s1 <= thr;
			hit_s1 <= (WAW'(rd_addr) < fill_q);
			last_s1 <= last;
		end
	end

	assign push = valid_s1;
	assign push_data = '{colour: rd_colour, thr: thr_s1, hit: hit_s1, frame_end: last_s1};

endmodule
`default_nettype wire

@@ rtl/core/lspwm_queue.sv @@
// Short register queue between the front end and the bit output stage.
`timescale 1ns / 1ps
`default_nettype none
module lspwm_queue
	import lspwm_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire qent_t          push_data,
	input  wire logic           pop,
	output qent_t               head,
	output logic [QCW-1:0]      level
);

	qent_t           entry_q [QUEUE_DEPTH];
	logic [QPW-1:0]  wr_ptr_q;
	logic [QPW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	assign head = entry_q[rd_ptr_q];
	assign level = count_q;

endmodule
`default_nettype wire

@@ rtl/core/lspwm_back.sv @@
// Back end: threshold compare and output register towards the LED boards.
`timescale 1ns / 1ps
`default_nettype none
module lspwm_back
	import lspwm_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire qent_t          head,
	input  wire logic [QCW-1:0] level,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_stall,
	output result_t             result_data
);

	logic    out_valid_q;
	result_t out_q;

	assign pop = (level != '0) && (!out_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.serial_bit <= head.hit && (head.colour > head.thr);
			out_q.frame_end <= head.frame_end;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data = out_q;

endmodule
`default_nettype wire

@@ rtl/core/led_shift_pwm_frame_driver_top.sv @@
// Top level of the LED shift-register PWM frame driver.
//
// Item channel (item_valid / item_stall / item_data): mode 0 carries a received
// byte that is written into the colour store, or restarts the write address when
// it matches sync_byte; mode 1 is a shift tick and produces exactly one result.
// Result channel (result_valid / result_stall / result_data): one serial bit per
// tick, with frame_end set on the last bit of a frame (latch follows).
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// board_count, index 1 is sync_byte; other indexes are ignored. cfg_ready is
// always high.
// Throughput: one request per cycle while item_stall is low, set by the single
// store read per tick in the front end. A tick's result passes through the read
// stage register, the queue and the output register before it is valid.
// Reset: all counters clear, write address and phase go to zero, and the whole
// store reads as zero via a fill mark; no clearing pass, items are taken at once.
// When the receiver stalls, results wait in the output register and a four-entry
// queue; item_stall rises once the queue and the read stage would overflow.
`timescale 1ns / 1ps
`default_nettype none
module led_shift_pwm_frame_driver_top
	import lspwm_pkg::*;
#(
	parameter int BOARDS = 64,
	parameter int PHASES = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire item_t      item_data,
	output logic            result_valid,
	input  wire logic       result_stall,
	output result_t         result_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	cfg_t           cfg_q;
	logic           push;
	qent_t          push_data;
	logic           pop;
	qent_t          head;
	logic [QCW-1:0] level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_count <= BOARD_COUNT_RST;
			cfg_q.sync_byte <= SYNC_BYTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BOARD_COUNT: cfg_q.board_count <= cfg_data[6:0];
				CFG_SYNC_BYTE: cfg_q.sync_byte <= cfg_data;
				default: ;
			endcase
		end
	end

	lspwm_front #(
		.BOARDS (BOARDS),
		.PHASES (PHASES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item_data   (item_data),
		.queue_level (level),
		.push        (push),
		.push_data   (push_data)
	);

	lspwm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.level     (level)
	);

	lspwm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.level        (level),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule
`default_nettype wire

@@ rtl/core/lspwm_checker.sv @@
// Port-level checks for the frame driver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lspwm_checker
	import lspwm_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire item_t      item_data,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire result_t    result_data,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready
);

	logic tick_acc;

	assign tick_acc = item_valid && !item_stall && item_data.mode;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result request dropped or changed");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !result_valid)
		else $error("result request present straight out of reset");

	// a fresh result needs an accepted tick that has passed the read stage, queue and output register
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |=> !result_valid || $past(tick_acc, 3))
		else $error("result request without a preceding tick");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config request not taken");

endmodule

bind led_shift_pwm_frame_driver_top lspwm_checker u_checker (.*);
`default_nettype wire
